>>> design/stsm_pkg.sv
// ----------------------------------------------------------------------------
// Sparse table second minimum: shared package
// Field widths, request and register codes, and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package stsm_pkg;

   localparam int REQ_W   = 2;
   localparam int INDEX_W = 10;
   localparam int QUERY_W = 11;
   localparam int TERM_W  = 11;
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_BUILD = 2'd1;
   localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

   // Register index, taken from paddr bit 2.
   localparam logic REG_TERM_COUNT = 1'b0;

   typedef enum logic [1:0] {
      PH_WHOLE = 2'd0,
      PH_LEFT  = 2'd1,
      PH_RIGHT = 2'd2
   } phase_type;

   typedef struct packed {
      logic      capture;
      logic      load_wr;
      logic      build_init;
      logic      build_read;
      logic      build_next;
      logic      q_start;
      logic      q_level;
      logic      q_read;
      logic      pick;
      phase_type phase;
      logic      out_load;
      logic      out_err;
   } cmd_type;

   typedef struct packed {
      logic load_hit;
      logic q_bad;
      logic level_fits;
      logic build_last;
      logic min_left;
      logic min_right;
      logic mpos_right;
      logic wr_pending;
   } status_type;

endpackage

>>> design/stsm_req_if.sv
// ----------------------------------------------------------------------------
// Sparse table second minimum: request channel
// Valid/ready channel carrying one load, build or query request.
// ----------------------------------------------------------------------------
interface stsm_req_if #(parameter int VALUE_WIDTH = 32);
   import stsm_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [REQ_W-1:0]              req_type;
   logic [INDEX_W-1:0]            element_index;
   logic signed [VALUE_WIDTH-1:0] element_value;
   logic [QUERY_W-1:0]            query_left;
   logic [QUERY_W-1:0]            query_right;

   modport source (output valid, req_type, element_index, element_value,
                   query_left, query_right, input ready);
   modport sink   (input valid, req_type, element_index, element_value,
                   query_left, query_right, output ready);
endinterface

>>> design/stsm_rsp_if.sv
// ----------------------------------------------------------------------------
// Sparse table second minimum: response channel
// Valid/ready channel carrying one query result.
// ----------------------------------------------------------------------------
interface stsm_rsp_if #(parameter int VALUE_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] second_min;
   logic                          has_second;
   logic                          range_error;

   modport source (output valid, second_min, has_second, range_error, input ready);
   modport sink   (input valid, second_min, has_second, range_error, output ready);
endinterface

>>> design/stsm_ctrl.sv
// ----------------------------------------------------------------------------
// Sparse table second minimum: controller
// Sequences loads, the level-by-level table build and the up to three
// range-minimum lookups of a query, and owns the built flag and output valid.
// ----------------------------------------------------------------------------
module stsm_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [stsm_pkg::REQ_W-1:0] req_kind,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic                     cfg_wr,
   input  stsm_pkg::status_type     status,
   output stsm_pkg::cmd_type        cmd
);
   import stsm_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_B_CHECK = 9'b000000010,
      S_B_READ  = 9'b000000100,
      S_B_DRAIN = 9'b000001000,
      S_Q_CHECK = 9'b000010000,
      S_Q_LEVEL = 9'b000100000,
      S_Q_READ  = 9'b001000000,
      S_Q_PICK  = 9'b010000000,
      S_Q_DONE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      built_ff, built_in;
   logic      q_err_ff, q_err_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      built_in     = built_ff;
      q_err_in     = q_err_ff;
      cmd          = '0;
      cmd.phase    = phase_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_kind)
                  REQ_LOAD: begin
                     cmd.load_wr = 1'b1;
                     if (status.load_hit) begin
                        built_in = 1'b0;
                     end
                  end
                  REQ_BUILD: begin
                     cmd.build_init = 1'b1;
                     state_in       = S_B_CHECK;
                  end
                  REQ_QUERY: begin
                     cmd.capture = 1'b1;
                     state_in    = S_Q_CHECK;
                  end
                  default: ;
               endcase
            end
         end
         S_B_CHECK: begin
            if (status.level_fits) begin
               state_in = S_B_READ;
            end else begin
               built_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_B_READ: begin
            cmd.build_read = 1'b1;
            if (status.build_last) begin
               state_in = S_B_DRAIN;
            end
         end
         S_B_DRAIN: begin
            // The last window of this level is written here, so the next
            // level reads it in time.
            cmd.build_next = 1'b1;
            state_in       = S_B_CHECK;
         end
         S_Q_CHECK: begin
            cmd.q_start = 1'b1;
            q_err_in    = !built_ff || status.q_bad;
            phase_in    = PH_WHOLE;
            state_in    = (!built_ff || status.q_bad) ? S_Q_DONE : S_Q_LEVEL;
         end
         S_Q_LEVEL: begin
            cmd.q_level = 1'b1;
            state_in    = S_Q_READ;
         end
         S_Q_READ: begin
            cmd.q_read = 1'b1;
            state_in   = S_Q_PICK;
         end
         S_Q_PICK: begin
            cmd.pick = 1'b1;
            case (phase_ff)
               PH_WHOLE: begin
                  if (status.min_left) begin
                     phase_in = PH_LEFT;
                     state_in = S_Q_LEVEL;
                  end else if (status.min_right) begin
                     phase_in = PH_RIGHT;
                     state_in = S_Q_LEVEL;
                  end else begin
                     state_in = S_Q_DONE;
                  end
               end
               PH_LEFT: begin
                  if (status.mpos_right) begin
                     phase_in = PH_RIGHT;
                     state_in = S_Q_LEVEL;
                  end else begin
                     state_in = S_Q_DONE;
                  end
               end
               default: state_in = S_Q_DONE;
            endcase
         end
         S_Q_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               cmd.out_err  = q_err_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (cfg_wr) begin
         built_in = 1'b0;
      end
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_WHOLE;
         built_ff     <= 1'b0;
         q_err_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         built_ff     <= built_in;
         q_err_ff     <= q_err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> design/stsm_dpath.sv
// ----------------------------------------------------------------------------
// Sparse table second minimum: datapath
// Holds the window-minimum table memory (one write port, two registered read
// ports), the build counters, the query segment registers and the result.
// ----------------------------------------------------------------------------
module stsm_dpath #(
   parameter int MAX_TERMS   = 1024,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  stsm_pkg::cmd_type             cmd,
   output stsm_pkg::status_type          status,
   input  logic                          cfg_wr,
   input  logic [stsm_pkg::TERM_W-1:0]   cfg_data,
   output logic [stsm_pkg::TERM_W-1:0]   term_count,
   input  logic [stsm_pkg::INDEX_W-1:0]  element_index,
   input  logic signed [VALUE_WIDTH-1:0] element_value,
   input  logic [stsm_pkg::QUERY_W-1:0]  query_left,
   input  logic [stsm_pkg::QUERY_W-1:0]  query_right,
   output logic signed [VALUE_WIDTH-1:0] second_min,
   output logic                          has_second,
   output logic                          range_error
);
   import stsm_pkg::*;

   localparam int CNT_W   = $clog2(MAX_TERMS + 1);
   localparam int LEVELS  = CNT_W;
   localparam int POS_W   = $clog2(MAX_TERMS);
   localparam int LVL_W   = $clog2(LEVELS);
   localparam int BLVL_W  = $clog2(LEVELS + 1);
   localparam int DEPTH   = LEVELS * MAX_TERMS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int QW      = (CNT_W > QUERY_W) ? CNT_W : QUERY_W;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] val;
      logic [POS_W-1:0]       pos;
   } entry_type;

   function automatic logic [ADDR_W-1:0] row_base(input logic [LVL_W-1:0] lvl);
      row_base = ADDR_W'(lvl) * ADDR_W'(MAX_TERMS);
   endfunction

   entry_type mem [DEPTH];

   logic [TERM_W-1:0]      term_count_ff;
   logic [CNT_W-1:0]       live_ff;
   logic [QUERY_W-1:0]     left_ff, right_ff;
   logic [BLVL_W-1:0]      blvl_ff;
   logic [POS_W-1:0]       bidx_ff;
   logic                   bwr_ff;
   logic [ADDR_W-1:0]      bwr_addr_ff;
   logic [POS_W-1:0]       qa_ff, qb_ff, lo_ff, hi_ff, mpos_ff;
   logic [LVL_W-1:0]       slvl_ff;
   logic [VALUE_WIDTH-1:0] best_ff;
   entry_type              rd_a_ff, rd_b_ff;
   logic [VALUE_WIDTH-1:0] second_ff;
   logic                   has_ff, err_ff;

   entry_type              pmin, wr_data;
   logic                   b_less_a;
   logic [CNT_W:0]         lvl_pow;
   logic [POS_W-1:0]       half;
   logic [LVL_W-1:0]       blvl_prev, blvl_cur;
   logic [CNT_W-1:0]       seg_len;
   logic [LVL_W-1:0]       seg_lvl;
   logic [POS_W-1:0]       q_b_start;
   logic [ADDR_W-1:0]      rd_addr_a, rd_addr_b, wr_addr;
   logic                   rd_en, wr_en, load_ok;

   // Pairs order by value, then by position.
   always_comb begin
      b_less_a = ($signed(rd_b_ff.val) < $signed(rd_a_ff.val)) ||
                 ((rd_b_ff.val == rd_a_ff.val) && (rd_b_ff.pos < rd_a_ff.pos));
      pmin     = b_less_a ? rd_b_ff : rd_a_ff;
   end

   always_comb begin
      lvl_pow   = (CNT_W + 1)'(1) << blvl_ff;
      half      = POS_W'(1) << (blvl_ff - BLVL_W'(1));
      blvl_prev = LVL_W'(blvl_ff - BLVL_W'(1));
      blvl_cur  = LVL_W'(blvl_ff);
      seg_len   = CNT_W'(hi_ff) - CNT_W'(lo_ff) + CNT_W'(1);
      seg_lvl   = '0;
      for (int b = 0; b < CNT_W; b++) begin
         if (seg_len[b]) begin
            seg_lvl = LVL_W'(b);
         end
      end
      q_b_start = POS_W'(CNT_W'(hi_ff) + CNT_W'(1) - (CNT_W'(1) << slvl_ff));
      load_ok   = QW'(element_index) < QW'(MAX_TERMS);
   end

   always_comb begin
      rd_en = cmd.build_read || cmd.q_read;
      if (cmd.build_read) begin
         rd_addr_a = row_base(blvl_prev) + ADDR_W'(bidx_ff);
         rd_addr_b = row_base(blvl_prev) + ADDR_W'(bidx_ff + half);
      end else begin
         rd_addr_a = row_base(slvl_ff) + ADDR_W'(lo_ff);
         rd_addr_b = row_base(slvl_ff) + ADDR_W'(q_b_start);
      end
      wr_en = bwr_ff || (cmd.load_wr && load_ok);
      if (bwr_ff) begin
         wr_addr = bwr_addr_ff;
         wr_data = pmin;
      end else begin
         // A load writes level zero; its position field equals its index.
         wr_addr     = ADDR_W'(element_index);
         wr_data.val = element_value;
         wr_data.pos = POS_W'(element_index);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         term_count_ff <= TERM_W'(1);
         live_ff       <= CNT_W'(1);
         bwr_ff        <= 1'b0;
      end else begin
         if (cfg_wr) begin
            term_count_ff <= cfg_data;
            live_ff <= (QW'(cfg_data) > QW'(MAX_TERMS)) ? CNT_W'(MAX_TERMS)
                                                       : CNT_W'(cfg_data);
         end
         bwr_ff <= cmd.build_read;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         left_ff  <= query_left;
         right_ff <= query_right;
      end
      if (cmd.build_init) begin
         blvl_ff <= BLVL_W'(1);
         bidx_ff <= '0;
      end else if (cmd.build_next) begin
         blvl_ff <= blvl_ff + BLVL_W'(1);
         bidx_ff <= '0;
      end else if (cmd.build_read) begin
         bidx_ff <= bidx_ff + POS_W'(1);
      end
      if (cmd.build_read) begin
         bwr_addr_ff <= row_base(blvl_cur) + ADDR_W'(bidx_ff);
      end
      if (cmd.q_start) begin
         qa_ff   <= POS_W'(left_ff - QUERY_W'(1));
         qb_ff   <= POS_W'(right_ff - QUERY_W'(1));
         lo_ff   <= POS_W'(left_ff - QUERY_W'(1));
         hi_ff   <= POS_W'(right_ff - QUERY_W'(1));
         best_ff <= {1'b0, {(VALUE_WIDTH - 1){1'b1}}};
      end
      if (cmd.q_level) begin
         slvl_ff <= seg_lvl;
      end
      if (cmd.pick) begin
         case (cmd.phase)
            PH_WHOLE: begin
               mpos_ff <= pmin.pos;
               if (pmin.pos > qa_ff) begin
                  lo_ff <= qa_ff;
                  hi_ff <= pmin.pos - POS_W'(1);
               end else begin
                  lo_ff <= pmin.pos + POS_W'(1);
                  hi_ff <= qb_ff;
               end
            end
            PH_LEFT: begin
               if ($signed(pmin.val) < $signed(best_ff)) begin
                  best_ff <= pmin.val;
               end
               lo_ff <= mpos_ff + POS_W'(1);
               hi_ff <= qb_ff;
            end
            default: begin
               if ($signed(pmin.val) < $signed(best_ff)) begin
                  best_ff <= pmin.val;
               end
            end
         endcase
      end
      if (cmd.out_load) begin
         second_ff <= cmd.out_err ? '0 : best_ff;
         has_ff    <= !cmd.out_err && (right_ff > left_ff);
         err_ff    <= cmd.out_err;
      end
   end

   always_comb begin
      status.load_hit   = load_ok;
      status.q_bad      = (left_ff == '0) || (left_ff > right_ff) ||
                          (QW'(right_ff) > QW'(live_ff));
      status.level_fits = lvl_pow <= (CNT_W + 1)'(live_ff);
      status.build_last = (CNT_W + 1)'(bidx_ff) == ((CNT_W + 1)'(live_ff) - lvl_pow);
      status.min_left   = pmin.pos > qa_ff;
      status.min_right  = pmin.pos < qb_ff;
      status.mpos_right = mpos_ff < qb_ff;
      status.wr_pending = bwr_ff;
   end

   assign term_count  = term_count_ff;
   assign second_min  = second_ff;
   assign has_second  = has_ff;
   assign range_error = err_ff;

endmodule

>>> design/sparse_table_second_minimum_unit.sv
// ----------------------------------------------------------------------------
// Sparse table second minimum unit
// Loads a sequence, builds a sparse table of (value, position) minima and
// answers second-minimum queries over one-based inclusive ranges.
//
//   Channel  Direction  Handshake          Contents
//   req_ch   in         valid/ready        load, build or query request
//   rsp_ch   out        valid/ready        second_min, has_second, range_error
//   APB      in         psel/penable       term_count at byte address 0
//
// A query needs one to three table lookups, which share the single table
// read pair; an error result needs none. A build fills every level j with
// 2^j <= n. Reset clears control state only; the table holds no reset
// value and needs no clearing pass. A finished query waits in the output
// register while the next request is taken in.
// ----------------------------------------------------------------------------
module sparse_table_second_minimum_unit #(
   parameter int MAX_TERMS   = 1024,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   stsm_req_if.sink                       req_ch,
   stsm_rsp_if.source                     rsp_ch,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [stsm_pkg::PADDR_W-1:0]   paddr,
   input  logic [stsm_pkg::PDATA_W-1:0]   pwdata,
   output logic [stsm_pkg::PDATA_W-1:0]   prdata,
   output logic                           pready
);
   import stsm_pkg::*;

   cmd_type           ctrl_cmd;
   status_type        dp_status;
   logic              cfg_wr;
   logic [TERM_W-1:0] term_count;
   logic              req_ready;
   logic              rsp_valid;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TERM_COUNT);
   assign prdata = (paddr[2] == REG_TERM_COUNT) ? PDATA_W'(term_count) : '0;

   stsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (req_ch.req_type),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .cfg_wr    (cfg_wr),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   stsm_dpath #(
      .MAX_TERMS   (MAX_TERMS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (ctrl_cmd),
      .status        (dp_status),
      .cfg_wr        (cfg_wr),
      .cfg_data      (pwdata[TERM_W-1:0]),
      .term_count    (term_count),
      .element_index (req_ch.element_index),
      .element_value (req_ch.element_value),
      .query_left    (req_ch.query_left),
      .query_right   (req_ch.query_right),
      .second_min    (rsp_ch.second_min),
      .has_second    (rsp_ch.has_second),
      .range_error   (rsp_ch.range_error)
   );

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;

   // The final write of a build level must land before new requests are taken.
   a_build_drained: assert property (@(posedge clock) disable iff (reset)
      dp_status.wr_pending |-> !req_ch.ready)
      else $error("table write still pending while requests are accepted");

   // A new result must never overwrite one that has not been transferred.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.out_load |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("result register loaded while holding an untaken result");

   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.range_error) |->
         ((rsp_ch.second_min == '0) && !rsp_ch.has_second))
      else $error("error result carries nonzero data fields");

endmodule
